// ----- hw/rtl/frad_pkg.sv -----
// Shared constants and types of the fractional-ratio averaging decimator.
`default_nettype none

package frad_pkg;

    // Default widths of the sample and count fields
    localparam int SAMPLE_BITS_DEF = 32;
    localparam int COUNT_BITS_DEF  = 16;

    // Entries of the queue between the front and the back end
    localparam int QUEUE_DEPTH = 2;

    // Configuration register index
    typedef logic [0:0] t_cfg_idx;

    localparam t_cfg_idx CFG_IN_COUNT  = 1'b0;
    localparam t_cfg_idx CFG_OUT_COUNT = 1'b1;

endpackage

`default_nettype wire

// ----- hw/rtl/frad_in_if.sv -----
// Source point channel: valid/ready handshake with the x and y samples.
`default_nettype none

interface frad_in_if #(
    parameter int SAMPLE_BITS = frad_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] x_value;
    logic signed [SAMPLE_BITS-1:0] y_value;

    modport source (output valid, output x_value, output y_value, input ready);
    modport sink   (input valid, input x_value, input y_value, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/frad_out_if.sv -----
// Averaged point channel: valid/ready handshake with averages, index and last flag.
`default_nettype none

interface frad_out_if #(
    parameter int SAMPLE_BITS = frad_pkg::SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = frad_pkg::COUNT_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] avg_x;
    logic signed [SAMPLE_BITS-1:0] avg_y;
    logic        [COUNT_BITS-1:0]  first_index;
    logic                          last_out;

    modport source (output valid, output avg_x, output avg_y, output first_index,
                    output last_out, input ready);
    modport sink   (input valid, input avg_x, input avg_y, input first_index,
                    input last_out, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/frad_front.sv -----
// Front end: configuration, group sizing and accumulation of the source points.
`default_nettype none

module frad_front #(
    parameter int SAMPLE_BITS = frad_pkg::SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = frad_pkg::COUNT_BITS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire frad_pkg::t_cfg_idx     i_cfg_idx,
    input  wire logic [COUNT_BITS-1:0]  i_cfg_data,
    frad_in_if.sink                     i_in,
    output logic                        o_push,
    output logic [2*(SAMPLE_BITS+COUNT_BITS)+2*COUNT_BITS:0] o_push_data,
    input  wire logic                   i_full
);

    localparam int SUMW = SAMPLE_BITS + COUNT_BITS;
    localparam int PW   = 2 * COUNT_BITS + 1;
    localparam int DCW  = $clog2(COUNT_BITS);

    typedef enum logic [4:0] {
        F_LOAD = 5'b00001,
        F_DIV  = 5'b00010,
        F_PROD = 5'b00100,
        F_SIZE = 5'b01000,
        F_RUN  = 5'b10000
    } t_fstate;

    t_fstate               r_state;
    logic [COUNT_BITS-1:0] r_in_count;
    logic [COUNT_BITS-1:0] r_out_count;

    // floor divider
    logic [COUNT_BITS-1:0] r_dq;
    logic [COUNT_BITS-1:0] r_drem;
    logic [DCW-1:0]        r_dcnt;
    logic [COUNT_BITS-1:0] r_floor;
    logic                  r_rem_nz;

    // group sizing
    logic [PW-1:0]         r_p1;
    logic [PW-1:0]         r_p2;
    logic                  r_avail;

    // run state
    logic [COUNT_BITS-1:0] r_group;
    logic [COUNT_BITS-1:0] r_consumed;
    logic [COUNT_BITS-1:0] r_inputs;
    logic [COUNT_BITS-1:0] r_gsize;
    logic [COUNT_BITS-1:0] r_ingrp;
    logic [SUMW-1:0]       r_sum_x;
    logic [SUMW-1:0]       r_sum_y;

    logic [COUNT_BITS-1:0] n_in;
    logic [COUNT_BITS-1:0] out_raw;
    logic [COUNT_BITS-1:0] n_out;

    logic [COUNT_BITS:0]   d_t;
    logic [COUNT_BITS:0]   d_sub;
    logic                  d_ge;
    logic [COUNT_BITS-1:0] d_rem_n;
    logic [COUNT_BITS-1:0] d_q_n;

    logic [COUNT_BITS:0]   g1;
    logic [COUNT_BITS:0]   cf;
    logic [PW-1:0]         p1_n;
    logic [PW-1:0]         p2_n;
    logic                  avail_n;

    logic                  sz_ceil;
    logic [COUNT_BITS:0]   sz_raw;
    logic [COUNT_BITS:0]   sz_end;
    logic [COUNT_BITS:0]   sz_cl;
    logic [COUNT_BITS-1:0] sz_n;

    logic                  in_fire;
    logic [SUMW-1:0]       x_ext;
    logic [SUMW-1:0]       y_ext;
    logic [SUMW-1:0]       sum_x_n;
    logic [SUMW-1:0]       sum_y_n;
    logic [COUNT_BITS:0]   ingrp_inc;
    logic                  grp_done;
    logic [COUNT_BITS:0]   end_pos;
    logic                  last_n;
    logic [COUNT_BITS:0]   inputs_inc;
    logic                  run_end;

    // Effective counts: zero acts as one, out_count clamped to in_count
    assign n_in    = (r_in_count == '0) ? COUNT_BITS'(1) : r_in_count;
    assign out_raw = (r_out_count == '0) ? COUNT_BITS'(1) : r_out_count;
    assign n_out   = (out_raw > n_in) ? n_in : out_raw;

    // One restoring step of in_count / out_count
    assign d_t     = {r_drem, r_dq[COUNT_BITS-1]};
    assign d_sub   = d_t - {1'b0, n_out};
    assign d_ge    = (d_t >= {1'b0, n_out});
    assign d_rem_n = d_ge ? d_sub[COUNT_BITS-1:0] : d_t[COUNT_BITS-1:0];
    assign d_q_n   = {r_dq[COUNT_BITS-2:0], d_ge};

    // Cross products for the ceil decision
    assign g1      = {1'b0, r_group} + (COUNT_BITS+1)'(1);
    assign cf      = {1'b0, r_consumed} + {1'b0, r_floor};
    assign p1_n    = {{COUNT_BITS{1'b0}}, g1} * {{(COUNT_BITS+1){1'b0}}, n_in};
    assign p2_n    = {{COUNT_BITS{1'b0}}, cf} * {{(COUNT_BITS+1){1'b0}}, n_out};
    assign avail_n = (r_group < n_out) && (r_consumed < n_in);

    // Pick floor or ceil, cut the group at the end of the run
    assign sz_ceil = (r_p1 > r_p2) && r_rem_nz;
    assign sz_raw  = {1'b0, r_floor} + (COUNT_BITS+1)'(sz_ceil);
    assign sz_end  = {1'b0, r_consumed} + sz_raw;
    assign sz_cl   = (sz_end > {1'b0, n_in}) ? ({1'b0, n_in} - {1'b0, r_consumed}) : sz_raw;
    assign sz_n    = r_avail ? sz_cl[COUNT_BITS-1:0] : '0;

    // Accumulate and detect group completion
    assign in_fire    = i_in.valid && i_in.ready;
    assign x_ext      = {{COUNT_BITS{i_in.x_value[SAMPLE_BITS-1]}}, i_in.x_value};
    assign y_ext      = {{COUNT_BITS{i_in.y_value[SAMPLE_BITS-1]}}, i_in.y_value};
    assign sum_x_n    = r_sum_x + x_ext;
    assign sum_y_n    = r_sum_y + y_ext;
    assign ingrp_inc  = {1'b0, r_ingrp} + (COUNT_BITS+1)'(1);
    assign grp_done   = (r_gsize != '0) && (ingrp_inc >= {1'b0, r_gsize});
    assign end_pos    = {1'b0, r_consumed} + {1'b0, r_gsize};
    assign last_n     = (g1 >= {1'b0, n_out}) || (end_pos >= {1'b0, n_in});
    assign inputs_inc = {1'b0, r_inputs} + (COUNT_BITS+1)'(1);
    assign run_end    = (inputs_inc >= {1'b0, n_in});

    assign i_in.ready  = (r_state == F_RUN) && !i_full;
    assign o_push      = in_fire && grp_done;
    assign o_push_data = {sum_x_n, sum_y_n, r_gsize, r_consumed, last_n};

    // Control and run state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= F_LOAD;
            r_in_count  <= COUNT_BITS'(1);
            r_out_count <= COUNT_BITS'(1);
            r_group     <= '0;
            r_consumed  <= '0;
            r_inputs    <= '0;
            r_gsize     <= '0;
            r_ingrp     <= '0;
            r_sum_x     <= '0;
            r_sum_y     <= '0;
        end else begin
            unique case (r_state)
                F_LOAD: begin
                    r_state <= F_DIV;
                end
                F_DIV: begin
                    if (r_dcnt == '0) begin
                        r_state <= (r_ingrp == '0) ? F_PROD : F_RUN;
                    end
                end
                F_PROD: begin
                    r_state <= F_SIZE;
                end
                F_SIZE: begin
                    r_gsize <= sz_n;
                    r_state <= F_RUN;
                end
                F_RUN: begin
                    if (in_fire) begin
                        if (grp_done) begin
                            r_consumed <= end_pos[COUNT_BITS-1:0];
                            r_group    <= g1[COUNT_BITS-1:0];
                            r_ingrp    <= '0;
                            r_gsize    <= '0;
                            r_sum_x    <= '0;
                            r_sum_y    <= '0;
                        end else if (r_gsize != '0) begin
                            r_sum_x <= sum_x_n;
                            r_sum_y <= sum_y_n;
                            r_ingrp <= ingrp_inc[COUNT_BITS-1:0];
                        end
                        // restart the run once in_count points are seen
                        if (run_end) begin
                            r_group    <= '0;
                            r_consumed <= '0;
                            r_inputs   <= '0;
                            r_gsize    <= '0;
                            r_ingrp    <= '0;
                            r_sum_x    <= '0;
                            r_sum_y    <= '0;
                        end else begin
                            r_inputs <= inputs_inc[COUNT_BITS-1:0];
                        end
                        if (grp_done || run_end) begin
                            r_state <= F_PROD;
                        end
                    end
                end
                default: begin
                    r_state <= F_LOAD;
                end
            endcase
            // a register write recomputes the ratio
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    frad_pkg::CFG_IN_COUNT:  r_in_count  <= i_cfg_data;
                    frad_pkg::CFG_OUT_COUNT: r_out_count <= i_cfg_data;
                    default: ;
                endcase
                r_state <= F_LOAD;
            end
        end
    end

    // Divider and sizing datapath
    always_ff @(posedge i_clk) begin
        if (r_state == F_LOAD) begin
            r_dq   <= n_in;
            r_drem <= '0;
            r_dcnt <= DCW'(COUNT_BITS - 1);
        end else if (r_state == F_DIV) begin
            r_dq   <= d_q_n;
            r_drem <= d_rem_n;
            r_dcnt <= r_dcnt - DCW'(1);
            if (r_dcnt == '0) begin
                r_floor  <= d_q_n;
                r_rem_nz <= (d_rem_n != '0);
            end
        end
        if (r_state == F_PROD) begin
            r_p1    <= p1_n;
            r_p2    <= p2_n;
            r_avail <= avail_n;
        end
    end

`ifndef SYNTHESIS
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> !i_full)
        else $error("group pushed into a full queue");

    a_group_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ingrp == '0) || (r_ingrp < r_gsize))
        else $error("group fill count reached the group size");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/frad_queue.sv -----
// Short register queue that carries finished group sums from front to back end.
`default_nettype none

module frad_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = frad_pkg::QUEUE_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_push_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_pop_data,
    output logic                  o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp;
    logic [AW-1:0]    r_rp;
    logic [CW-1:0]    r_cnt;

    assign o_full     = (r_cnt == CW'(DEPTH));
    assign o_empty    = (r_cnt == '0);
    assign o_pop_data = r_mem[r_rp];

    // Advance pointers and the fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    // Store the entry
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_push_data;
        end
    end

`ifndef SYNTHESIS
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_cnt != '0))
        else $error("queue popped while empty");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/frad_back.sv -----
// Back end: divides the group sums by the group size and holds the result.
`default_nettype none

module frad_back #(
    parameter int SAMPLE_BITS = frad_pkg::SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = frad_pkg::COUNT_BITS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_empty,
    output logic                        o_pop,
    input  wire logic [2*(SAMPLE_BITS+COUNT_BITS)+2*COUNT_BITS:0] i_pop_data,
    frad_out_if.source                  o_out
);

    localparam int SUMW = SAMPLE_BITS + COUNT_BITS;
    localparam int QW   = 2 * SUMW + 2 * COUNT_BITS + 1;
    localparam int CW   = $clog2(SAMPLE_BITS);

    typedef enum logic [2:0] {
        B_IDLE = 3'b001,
        B_DIV  = 3'b010,
        B_DONE = 3'b100
    } t_bstate;

    t_bstate                r_state;
    logic [CW-1:0]          r_cnt;
    logic                   r_neg_x;
    logic                   r_neg_y;
    logic [SAMPLE_BITS-1:0] r_qx;
    logic [SAMPLE_BITS-1:0] r_qy;
    logic [COUNT_BITS-1:0]  r_rx;
    logic [COUNT_BITS-1:0]  r_ry;
    logic [COUNT_BITS-1:0]  r_div;
    logic [COUNT_BITS-1:0]  r_first;
    logic                   r_last;

    logic                   r_ov;
    logic [SAMPLE_BITS-1:0] r_ax;
    logic [SAMPLE_BITS-1:0] r_ay;
    logic [COUNT_BITS-1:0]  r_fi;
    logic                   r_lo;

    logic [SUMW-1:0]        e_sum_x;
    logic [SUMW-1:0]        e_sum_y;
    logic [COUNT_BITS-1:0]  e_size;
    logic [COUNT_BITS-1:0]  e_first;
    logic                   e_last;
    logic [SUMW-1:0]        mag_x;
    logic [SUMW-1:0]        mag_y;

    logic [COUNT_BITS:0]    tx;
    logic [COUNT_BITS:0]    ty;
    logic [COUNT_BITS:0]    sub_x;
    logic [COUNT_BITS:0]    sub_y;
    logic                   ge_x;
    logic                   ge_y;
    logic                   load_out;

    // Unpack the queue entry
    assign e_sum_x = i_pop_data[QW-1 -: SUMW];
    assign e_sum_y = i_pop_data[QW-1-SUMW -: SUMW];
    assign e_size  = i_pop_data[2*COUNT_BITS -: COUNT_BITS];
    assign e_first = i_pop_data[COUNT_BITS -: COUNT_BITS];
    assign e_last  = i_pop_data[0];

    assign mag_x = e_sum_x[SUMW-1] ? (~e_sum_x + SUMW'(1)) : e_sum_x;
    assign mag_y = e_sum_y[SUMW-1] ? (~e_sum_y + SUMW'(1)) : e_sum_y;

    // One restoring division step per sum
    assign tx    = {r_rx, r_qx[SAMPLE_BITS-1]};
    assign ty    = {r_ry, r_qy[SAMPLE_BITS-1]};
    assign sub_x = tx - {1'b0, r_div};
    assign sub_y = ty - {1'b0, r_div};
    assign ge_x  = (tx >= {1'b0, r_div});
    assign ge_y  = (ty >= {1'b0, r_div});

    assign o_pop    = (r_state == B_IDLE) && !i_empty;
    assign load_out = (r_state == B_DONE) && (!r_ov || o_out.ready);

    assign o_out.valid       = r_ov;
    assign o_out.avg_x       = r_ax;
    assign o_out.avg_y       = r_ay;
    assign o_out.first_index = r_fi;
    assign o_out.last_out    = r_lo;

    // Sequence pop, division and hand-off
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_ov    <= 1'b0;
        end else begin
            unique case (r_state)
                B_IDLE: begin
                    if (o_pop) begin
                        r_state <= (e_size == COUNT_BITS'(1)) ? B_DONE : B_DIV;
                    end
                end
                B_DIV: begin
                    if (r_cnt == '0) begin
                        r_state <= B_DONE;
                    end
                end
                B_DONE: begin
                    if (load_out) begin
                        r_state <= B_IDLE;
                    end
                end
                default: begin
                    r_state <= B_IDLE;
                end
            endcase
            if (load_out) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Divider datapath
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_neg_x <= e_sum_x[SUMW-1];
            r_neg_y <= e_sum_y[SUMW-1];
            r_qx    <= mag_x[SAMPLE_BITS-1:0];
            r_qy    <= mag_y[SAMPLE_BITS-1:0];
            r_rx    <= mag_x[SUMW-1:SAMPLE_BITS];
            r_ry    <= mag_y[SUMW-1:SAMPLE_BITS];
            r_div   <= e_size;
            r_first <= e_first;
            r_last  <= e_last;
            r_cnt   <= CW'(SAMPLE_BITS - 1);
        end else if (r_state == B_DIV) begin
            r_qx  <= {r_qx[SAMPLE_BITS-2:0], ge_x};
            r_qy  <= {r_qy[SAMPLE_BITS-2:0], ge_y};
            r_rx  <= ge_x ? sub_x[COUNT_BITS-1:0] : tx[COUNT_BITS-1:0];
            r_ry  <= ge_y ? sub_y[COUNT_BITS-1:0] : ty[COUNT_BITS-1:0];
            r_cnt <= r_cnt - CW'(1);
        end
    end

    // Output register: restore the sign, truncated toward zero
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_ax <= r_neg_x ? (~r_qx + SAMPLE_BITS'(1)) : r_qx;
            r_ay <= r_neg_y ? (~r_qy + SAMPLE_BITS'(1)) : r_qy;
            r_fi <= r_first;
            r_lo <= r_last;
        end
    end

`ifndef SYNTHESIS
    a_size_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (e_size != '0))
        else $error("group of size zero reached the divider");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_DIV) |-> ((r_rx < r_div) && (r_ry < r_div)))
        else $error("divider remainder not below the group size");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/fractional_ratio_average_decimator_top.sv -----
// Top level of the fractional-ratio averaging decimator.
// Usage: write in_count (index 0) and out_count (index 1) through the write port
// while the block is idle; then stream source points on i_in. Each run of in_count
// points is cut into out_count groups of floor or ceil of in_count/out_count
// points; one averaged point per group leaves on o_out with the index of its
// first source point and last_out set on the run's final group. Points after
// the final group are only counted toward the end of the run.
// Throughput: the front end takes one point per cycle inside a group while the
// queue has room, and pauses at each group start for the size multiply and
// compare. The back end divides one group at a time on its bit-serial divider
// and pops no new group until the last is in its output register; single-point
// groups skip the division. A two-entry queue lets both ends run apart.
// Reset and each register write run a COUNT_BITS-step division of the counts;
// i_in.ready stays low after either while it runs and, at a group start, while
// the first group is sized (reset counts: 1 and 1).
// A stalled o_out holds its transaction; the back end then stops, the queue
// fills, and i_in.ready drops until room returns.
`default_nettype none

module fractional_ratio_average_decimator_top #(
    parameter int SAMPLE_BITS = frad_pkg::SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = frad_pkg::COUNT_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire frad_pkg::t_cfg_idx    i_cfg_idx,
    input  wire logic [COUNT_BITS-1:0] i_cfg_data,
    frad_in_if.sink                    i_in,
    frad_out_if.source                 o_out
);

    localparam int QW = 2 * (SAMPLE_BITS + COUNT_BITS) + 2 * COUNT_BITS + 1;

    logic          q_push;
    logic [QW-1:0] q_push_data;
    logic          q_full;
    logic          q_pop;
    logic [QW-1:0] q_pop_data;
    logic          q_empty;

    frad_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in        (i_in),
        .o_push      (q_push),
        .o_push_data (q_push_data),
        .i_full      (q_full)
    );

    frad_queue #(
        .WIDTH (QW),
        .DEPTH (frad_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (q_push_data),
        .o_full      (q_full),
        .i_pop       (q_pop),
        .o_pop_data  (q_pop_data),
        .o_empty     (q_empty)
    );

    frad_back #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (q_empty),
        .o_pop      (q_pop),
        .i_pop_data (q_pop_data),
        .o_out      (o_out)
    );

endmodule

`default_nettype wire

// ----- verif/fractional_ratio_average_decimator_top_test.sv -----
// Self-checking testbench of the fractional-ratio averaging decimator top level.
`timescale 1ns / 100ps

module fractional_ratio_average_decimator_top_test;

    localparam int SAMPLE_W     = frad_pkg::SAMPLE_BITS_DEF;
    localparam int COUNT_W      = frad_pkg::COUNT_BITS_DEF;
    localparam int DRAIN_CYCLES = 2 * (SAMPLE_W + 2);
    localparam int LIMIT_CYCLES = 400000;
    localparam int REPORT_MAX   = 10;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    // One averaged point as it leaves the block
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] avg_x;
        logic signed [SAMPLE_W-1:0] avg_y;
        logic [COUNT_W-1:0]         first_index;
        logic                       last_out;
    } t_avg_point;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    frad_pkg::t_cfg_idx i_cfg_idx;
    logic [COUNT_W-1:0] i_cfg_data;

    frad_in_if  #(.SAMPLE_BITS(SAMPLE_W)) in_ch ();
    frad_out_if #(.SAMPLE_BITS(SAMPLE_W), .COUNT_BITS(COUNT_W)) out_ch ();

    fractional_ratio_average_decimator_top #(
        .SAMPLE_BITS(SAMPLE_W),
        .COUNT_BITS (COUNT_W)
    ) uut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_in      (in_ch),
        .o_out     (out_ch)
    );

    // Expected averaged points, oldest first
    t_avg_point pending_points[$];
    int         mismatch_count;
    int         cycle_count;

    // Traffic shaping knobs
    int sender_idle_pct;
    int recv_stall_pct;
    int recv_hold_left;

    // Shadow registers and group state of the decimator
    logic [COUNT_W-1:0] cfg_in_count;
    logic [COUNT_W-1:0] cfg_out_count;
    longint grp_num;
    longint grp_start;
    longint run_inputs;
    longint grp_size;
    longint grp_fill;
    longint acc_x;
    longint acc_y;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Clear the group state at a run boundary
    function automatic void restart_groups();
        grp_num    = 0;
        grp_start  = 0;
        run_inputs = 0;
        grp_size   = 0;
        grp_fill   = 0;
        acc_x      = 0;
        acc_y      = 0;
    endfunction

    // Advance the group state by one source point; return 1 when a group closes
    function automatic bit predict_average(input logic signed [SAMPLE_W-1:0] x,
                                           input logic signed [SAMPLE_W-1:0] y,
                                           output t_avg_point pt);
        longint n_in;
        longint n_out;
        longint fl;
        longint sz;
        longint end_idx;
        longint quot;
        bit     made;
        made = 1'b0;
        pt   = '0;
        n_in  = (cfg_in_count == 0) ? 1 : longint'(cfg_in_count);
        n_out = (cfg_out_count == 0) ? 1 : longint'(cfg_out_count);
        if (n_out > n_in)
            n_out = n_in;

        // Size the group at its first point
        if (grp_fill == 0) begin
            if (grp_num < n_out && grp_start < n_in) begin
                fl = n_in / n_out;
                sz = fl;
                if ((grp_num + 1) * n_in > (grp_start + fl) * n_out)
                    sz = fl + (((n_in % n_out) != 0) ? 1 : 0);
                if (grp_start + sz > n_in)
                    sz = n_in - grp_start;
                grp_size = sz;
            end else begin
                grp_size = 0;
            end
        end

        // Accumulate and close the group
        if (grp_size != 0) begin
            acc_x += longint'(x);
            acc_y += longint'(y);
            grp_fill++;
            if (grp_fill >= grp_size) begin
                end_idx        = grp_start + grp_size;
                quot           = acc_x / grp_size;
                pt.avg_x       = quot[SAMPLE_W-1:0];
                quot           = acc_y / grp_size;
                pt.avg_y       = quot[SAMPLE_W-1:0];
                pt.first_index = grp_start[COUNT_W-1:0];
                pt.last_out    = (grp_num + 1 >= n_out || end_idx >= n_in);
                made      = 1'b1;
                grp_start = end_idx;
                grp_num++;
                grp_fill  = 0;
                grp_size  = 0;
                acc_x     = 0;
                acc_y     = 0;
            end
        end

        // Restart once the run is complete
        run_inputs++;
        if (run_inputs >= n_in)
            restart_groups();
        return made;
    endfunction

    // Mix of extremes, small values around zero and full-range values
    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(0, 5))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2:       return SAMPLE_W'($signed($urandom_range(0, 200)) - 100);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // Offer one point, hold it until accepted, then predict its result
    task automatic send_point(input logic signed [SAMPLE_W-1:0] x,
                              input logic signed [SAMPLE_W-1:0] y);
        t_avg_point pt;
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.x_value <= x;
        in_ch.y_value <= y;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        if (predict_average(x, y, pt))
            pending_points.push_back(pt);
        @(negedge i_clk);
    endtask

    // Drain the block, then write both count registers
    task automatic set_counts(input int in_cnt, input int out_cnt);
        in_ch.valid <= 1'b0;
        while (pending_points.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= frad_pkg::CFG_IN_COUNT;
        i_cfg_data <= COUNT_W'(in_cnt);
        @(negedge i_clk);
        i_cfg_idx  <= frad_pkg::CFG_OUT_COUNT;
        i_cfg_data <= COUNT_W'(out_cnt);
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        cfg_in_count  = COUNT_W'(in_cnt);
        cfg_out_count = COUNT_W'(out_cnt);
    endtask

    // Receiver: long hold-off first, otherwise random stalls
    initial begin
        forever begin
            @(negedge i_clk);
            if (recv_hold_left > 0) begin
                recv_hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // Check each accepted averaged point against the oldest expectation
    always @(posedge i_clk) begin
        t_avg_point exp_pt;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_points.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("%0t: unexpected point x=%0d y=%0d idx=%0d last=%0b", $time,
                             out_ch.avg_x, out_ch.avg_y, out_ch.first_index, out_ch.last_out);
            end else begin
                exp_pt = pending_points.pop_front();
                if (out_ch.avg_x !== exp_pt.avg_x || out_ch.avg_y !== exp_pt.avg_y ||
                    out_ch.first_index !== exp_pt.first_index ||
                    out_ch.last_out !== exp_pt.last_out) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("%0t: mismatch exp x=%0d y=%0d idx=%0d last=%0b, got x=%0d y=%0d idx=%0d last=%0b",
                                 $time, exp_pt.avg_x, exp_pt.avg_y, exp_pt.first_index,
                                 exp_pt.last_out, out_ch.avg_x, out_ch.avg_y,
                                 out_ch.first_index, out_ch.last_out);
                end
            end
        end
    end

    // Watchdog
    initial begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d points outstanding",
                 cycle_count, pending_points.size());
        $display("FAIL");
        $finish;
    end

    // Reset counts of one in, one out: every point comes back as itself
    task automatic test_reset_counts();
        send_point(SAMPLE_MAX, SAMPLE_MIN);
        send_point(SAMPLE_MIN, SAMPLE_MAX);
    endtask

    // Full-scale sums and truncation toward zero of negative averages
    task automatic test_sample_extremes();
        set_counts(2, 1);
        send_point(SAMPLE_MAX, SAMPLE_MAX);
        send_point(SAMPLE_MAX, SAMPLE_MAX);
        send_point(-1, SAMPLE_MIN);
        send_point(0, SAMPLE_MIN + 1);
    endtask

    // Uneven ratio: mix of floor and ceil sized groups
    task automatic test_fractional_groups();
        set_counts(7, 3);
        repeat (7) send_point(rand_sample(), rand_sample());
    endtask

    // Widest counts, changes mid-run, trailing points, clamp and zero counts
    task automatic test_count_limits();
        set_counts(16'hFFFF, 16'hFFFF);
        repeat (6) send_point(rand_sample(), rand_sample());
        set_counts(16'hFFFF, 1);
        repeat (3) send_point(rand_sample(), rand_sample());
        set_counts(1, 16'hFFFF);
        repeat (3) send_point(rand_sample(), rand_sample());
        set_counts(0, 0);
        send_point(rand_sample(), rand_sample());
    endtask

    // Hold the receiver off while points keep coming so the input stalls
    task automatic test_receiver_hold();
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        set_counts(2, 2);
        recv_hold_left = 400;
        repeat (40) send_point(rand_sample(), rand_sample());
    endtask

    // Random runs under one traffic profile
    task automatic test_random_runs(input int idle_pct, input int stall_pct,
                                    input int item_total);
        int sent;
        int n_in;
        int n_out;
        int eff_in;
        int run_len;
        sender_idle_pct = idle_pct;
        recv_stall_pct  = stall_pct;
        sent = 0;
        while (sent < item_total) begin
            case ($urandom_range(0, 9))
                0: begin
                    n_in  = $urandom_range(25, 120);
                    n_out = $urandom_range(1, 6);
                end
                1: begin
                    n_in  = $urandom_range(1, 16);
                    n_out = n_in + $urandom_range(1, 5);
                end
                2: begin
                    n_in  = $urandom_range(0, 12);
                    n_out = 0;
                end
                3: begin
                    n_in  = 0;
                    n_out = $urandom_range(1, 3);
                end
                default: begin
                    n_in  = $urandom_range(1, 24);
                    n_out = $urandom_range(1, n_in);
                end
            endcase
            set_counts(n_in, n_out);
            eff_in  = (n_in == 0) ? 1 : n_in;
            run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, eff_in) : eff_in;
            if (run_len > item_total - sent)
                run_len = item_total - sent;
            repeat (run_len) send_point(rand_sample(), rand_sample());
            sent += run_len;
        end
    endtask

    // Sequence the tests
    initial begin
        mismatch_count  = 0;
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        recv_hold_left  = 0;
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= frad_pkg::CFG_IN_COUNT;
        i_cfg_data      <= '0;
        in_ch.valid     <= 1'b0;
        in_ch.x_value   <= '0;
        in_ch.y_value   <= '0;
        out_ch.ready    <= 1'b0;
        cfg_in_count  = 1;
        cfg_out_count = 1;
        restart_groups();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_counts();
        test_sample_extremes();
        test_fractional_groups();
        test_count_limits();
        test_receiver_hold();
        test_random_runs(0, 0, 360);
        test_random_runs(61, 0, 360);
        test_random_runs(0, 61, 360);
        test_random_runs(23, 23, 360);

        // Drain and settle
        in_ch.valid <= 1'b0;
        while (pending_points.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatch_count == 0 && pending_points.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
